>>> rtl/bzr_pkg.sv
package bzr_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int T_FRAC_BITS    = 16;
  localparam int OUT_BITS       = 24;
  localparam int OUT_MAX        = 8388607;
  localparam int OUT_MIN        = -8388608;

  localparam int NUM_REGS     = 8;
  localparam int REG_IDX_BITS = 3;
  localparam int ADDR_BITS    = 5;
  localparam int DATA_BITS    = 32;

  localparam int REG_P0_X = 0;
  localparam int REG_P1_X = 2;
  localparam int REG_P2_X = 4;
  localparam int REG_P3_X = 6;

  // Width of the slices that the wide difference operand is cut into for multiplication.
  localparam int PP_CHUNK = 24;

  typedef enum logic [1:0] {
    FUNC_POS,
    FUNC_D1,
    FUNC_D2,
    FUNC_D3
  } func_t;

  typedef struct packed {
    func_t                func;
    logic [T_FRAC_BITS:0] t;
  } req_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] out_x;
    logic signed [OUT_BITS-1:0] out_y;
  } rsp_t;

  typedef struct packed {
    logic diff;
    logic mul;
    logic sum;
  } lerp_en_t;

endpackage

>>> rtl/bzr_cfg.sv
module bzr_cfg #(
  parameter int COORD_BITS = bzr_pkg::COORD_BITS_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          psel,
  input  logic                                          penable,
  input  logic                                          pwrite,
  input  logic [bzr_pkg::ADDR_BITS-1:0]                 paddr,
  input  logic [bzr_pkg::DATA_BITS-1:0]                 pwdata,
  output logic [bzr_pkg::DATA_BITS-1:0]                 prdata,
  output logic                                          pready,
  output logic [bzr_pkg::NUM_REGS-1:0][COORD_BITS-1:0]  pts
);

  logic [bzr_pkg::REG_IDX_BITS-1:0] idx;

  assign idx    = paddr[bzr_pkg::ADDR_BITS-1:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pts <= '0;
    end else if (psel && penable && pwrite) begin
      pts[idx] <= pwdata[COORD_BITS-1:0];
    end
  end

  assign prdata = bzr_pkg::DATA_BITS'(pts[idx]);

endmodule

>>> rtl/bzr_hull.sv
module bzr_hull #(
  parameter int COORD_BITS = bzr_pkg::COORD_BITS_DEF
) (
  input  logic                                          clk,
  input  logic                                          en,
  input  logic [bzr_pkg::NUM_REGS-1:0][COORD_BITS-1:0]  pts,
  input  bzr_pkg::req_t                                 req,
  output logic [1:0][3:0][COORD_BITS+5:0]               hull,
  output bzr_pkg::func_t                                func,
  output logic [bzr_pkg::T_FRAC_BITS:0]                 t
);

  localparam int HW = COORD_BITS + 6;
  localparam int T  = bzr_pkg::T_FRAC_BITS;
  localparam logic [T:0] T_ONE = {1'b1, {T{1'b0}}};

  logic signed [HW-1:0] p  [0:1][0:3];
  logic signed [HW-1:0] d1 [0:1][0:2];
  logic signed [HW-1:0] d2 [0:1][0:1];
  logic signed [HW-1:0] d3 [0:1];
  logic [1:0][3:0][HW-1:0] hull_next;
  logic [T:0] t_sat;

  assign t_sat = (req.t > T_ONE) ? T_ONE : req.t;

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      p[a][0] = HW'($signed(pts[bzr_pkg::REG_P0_X + a]));
      p[a][1] = HW'($signed(pts[bzr_pkg::REG_P1_X + a]));
      p[a][2] = HW'($signed(pts[bzr_pkg::REG_P2_X + a]));
      p[a][3] = HW'($signed(pts[bzr_pkg::REG_P3_X + a]));
      for (int k = 0; k < 3; k++) begin
        d1[a][k] = ((p[a][k+1] - p[a][k]) <<< 1) + (p[a][k+1] - p[a][k]);
      end
      for (int k = 0; k < 2; k++) begin
        d2[a][k] = (d1[a][k+1] - d1[a][k]) <<< 1;
      end
      d3[a] = d2[a][1] - d2[a][0];
      hull_next[a] = '0;
      case (req.func)
        bzr_pkg::FUNC_POS: begin
          for (int k = 0; k < 4; k++) hull_next[a][k] = p[a][k];
        end
        bzr_pkg::FUNC_D1: begin
          for (int k = 0; k < 3; k++) hull_next[a][k] = d1[a][k];
        end
        bzr_pkg::FUNC_D2: begin
          for (int k = 0; k < 2; k++) hull_next[a][k] = d2[a][k];
        end
        default: begin
          hull_next[a][0] = d3[a];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hull <= hull_next;
      func <= req.func;
      t    <= t_sat;
    end
  end

endmodule

>>> rtl/bzr_lerp.sv
module bzr_lerp #(
  parameter int IW = bzr_pkg::COORD_BITS_DEF + 6
) (
  input  logic                                     clk,
  input  bzr_pkg::lerp_en_t                        en,
  input  logic [IW-1:0]                            a,
  input  logic [IW-1:0]                            b,
  input  logic [bzr_pkg::T_FRAC_BITS:0]            t,
  output logic [IW+bzr_pkg::T_FRAC_BITS:0]         y
);

  localparam int T  = bzr_pkg::T_FRAC_BITS;
  localparam int CH = bzr_pkg::PP_CHUNK;
  localparam int OW = IW + T + 1;
  localparam int DW = IW + 1;
  localparam int ND = (DW + CH - 1) / CH;
  localparam int PW = CH + T + 3;
  localparam int SW = ND * CH + T + 3;

  // a*(1-t) + b*t is formed as a*S + (b-a)*t, so only the difference is multiplied.
  logic signed [IW-1:0]    aq;
  logic signed [DW-1:0]    dq;
  logic signed [IW-1:0]    a2q;
  logic [ND*CH-1:0]        dx;
  logic signed [PW-1:0]    pq [0:ND-1];
  logic signed [SW-1:0]    acc;

  always_ff @(posedge clk) begin
    if (en.diff) begin
      aq <= $signed(a);
      dq <= DW'($signed(b)) - DW'($signed(a));
    end
  end

  assign dx = (ND*CH)'(dq);

  for (genvar i = 0; i < ND; i++) begin : g_pp
    if (i < ND - 1) begin : g_low
      always_ff @(posedge clk) begin
        if (en.mul) begin
          pq[i] <= $signed({1'b0, dx[i*CH +: CH]}) * $signed({1'b0, t});
        end
      end
    end else begin : g_top
      always_ff @(posedge clk) begin
        if (en.mul) begin
          pq[i] <= $signed(dx[i*CH +: CH]) * $signed({1'b0, t});
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.mul) begin
      a2q <= aq;
    end
  end

  always_comb begin
    acc = SW'(a2q) <<< T;
    for (int i = 0; i < ND; i++) begin
      acc = acc + (SW'(pq[i]) <<< (i * CH));
    end
  end

  always_ff @(posedge clk) begin
    if (en.sum) begin
      y <= acc[OW-1:0];
    end
  end

endmodule

>>> rtl/bzr_round.sv
module bzr_round #(
  parameter int VW    = bzr_pkg::COORD_BITS_DEF + 6 + 3 * (bzr_pkg::T_FRAC_BITS + 1),
  parameter int SHIFT = 3 * bzr_pkg::T_FRAC_BITS
) (
  input  logic [VW-1:0]                        v,
  output logic signed [bzr_pkg::OUT_BITS-1:0]  q
);

  localparam int RW = VW - SHIFT + 1;
  localparam int CW = (RW > bzr_pkg::OUT_BITS + 1) ? RW : bzr_pkg::OUT_BITS + 1;
  localparam logic signed [VW:0] HALF = {{(VW-SHIFT+1){1'b0}}, 1'b1, {(SHIFT-1){1'b0}}};
  localparam logic signed [CW-1:0] SAT_HI = CW'(bzr_pkg::OUT_MAX);
  localparam logic signed [CW-1:0] SAT_LO = CW'(bzr_pkg::OUT_MIN);

  logic signed [VW:0]   sum;
  logic signed [RW-1:0] r;
  logic signed [CW-1:0] rx;

  // Adding one half before the arithmetic shift sends ties towards plus infinity.
  assign sum = $signed({v[VW-1], v}) + HALF;
  assign r   = $signed(sum[VW:SHIFT]);
  assign rx  = CW'(r);

  always_comb begin
    if (rx > SAT_HI) begin
      q = bzr_pkg::OUT_BITS'(bzr_pkg::OUT_MAX);
    end else if (rx < SAT_LO) begin
      q = bzr_pkg::OUT_BITS'(bzr_pkg::OUT_MIN);
    end else begin
      q = rx[bzr_pkg::OUT_BITS-1:0];
    end
  end

endmodule

>>> rtl/cubic_bezier_point_and_derivatives_top.sv
// Channel   Dir  Handshake                 Payload
// req       in   req_valid / req_ready     bzr_pkg::req_t  (func, t)
// rsp       out  rsp_valid / rsp_ready     bzr_pkg::rsp_t  (out_x, out_y)
// config    in   APB psel/penable/pwrite   paddr, pwdata, prdata, pready
//
// One transaction may enter every cycle while req_ready is high; each gives one result.
// The pipeline has one hull stage, three de Casteljau levels of
// three stages each (difference, sliced multiply, sum) and the output register.
// Reset (rst, synchronous) clears the stage valid bits and the control points.
// Each stage holds while the one after it is full and stalled, so bubbles close up
// and req_ready falls only when every stage is occupied and rsp is stalled.
module cubic_bezier_point_and_derivatives_top #(
  parameter int COORD_BITS = bzr_pkg::COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_ready,
  input  bzr_pkg::req_t                  req,
  output logic                           rsp_valid,
  input  logic                           rsp_ready,
  output bzr_pkg::rsp_t                  rsp,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bzr_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [bzr_pkg::DATA_BITS-1:0]  pwdata,
  output logic [bzr_pkg::DATA_BITS-1:0]  prdata,
  output logic                           pready
);

  localparam int T   = bzr_pkg::T_FRAC_BITS;
  localparam int HW  = COORD_BITS + 6;
  localparam int W3  = HW + 3 * (T + 1);
  localparam int NST = 11;

  logic [bzr_pkg::NUM_REGS-1:0][COORD_BITS-1:0] pts;
  logic [1:0][3:0][HW-1:0]  hull;
  bzr_pkg::func_t           h_func;
  logic [T:0]               h_t;

  logic [NST-1:0] v;
  logic [NST:0]   en;

  logic [T:0]     tp [1:7];
  bzr_pkg::func_t fp [1:6];
  bzr_pkg::func_t fsel [0:2];
  logic [T:0]     tsel [0:2];

  logic [W3-1:0] lvl [0:1][0:3][0:3];
  logic signed [bzr_pkg::OUT_BITS-1:0] res [0:1];
  bzr_pkg::rsp_t rsp_q;

  bzr_cfg #(.COORD_BITS(COORD_BITS)) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .pts     (pts)
  );

  bzr_hull #(.COORD_BITS(COORD_BITS)) u_hull (
    .clk  (clk),
    .en   (en[0]),
    .pts  (pts),
    .req  (req),
    .hull (hull),
    .func (h_func),
    .t    (h_t)
  );

  // Stall chain: a stage may load when it is empty or when its successor loads.
  assign en[NST] = rsp_ready;
  for (genvar i = 0; i < NST; i++) begin : g_en
    assign en[i] = ~v[i] | en[i+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= req_valid;
      for (int i = 1; i < NST; i++) begin
        if (en[i]) v[i] <= v[i-1];
      end
    end
  end

  for (genvar i = 1; i <= 7; i++) begin : g_tp
    if (i == 1) begin : g_first
      always_ff @(posedge clk) begin
        if (en[i]) tp[i] <= h_t;
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (en[i]) tp[i] <= tp[i-1];
      end
    end
  end

  for (genvar i = 1; i <= 6; i++) begin : g_fp
    if (i == 1) begin : g_first
      always_ff @(posedge clk) begin
        if (en[i]) fp[i] <= h_func;
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (en[i]) fp[i] <= fp[i-1];
      end
    end
  end

  assign fsel[0] = h_func;
  assign fsel[1] = fp[3];
  assign fsel[2] = fp[6];
  assign tsel[0] = tp[1];
  assign tsel[1] = tp[4];
  assign tsel[2] = tp[7];

  // Levels numbered below the derivative order only scale by one (b taken equal to a), so
  // every order leaves the pipeline scaled by the same power of two.
  for (genvar a = 0; a < 2; a++) begin : g_axis
    for (genvar k = 0; k < 4; k++) begin : g_in
      assign lvl[a][0][k] = W3'($signed(hull[a][k]));
    end
    for (genvar l = 0; l < 3; l++) begin : g_lvl
      localparam int IW = HW + l * (T + 1);
      for (genvar k = 0; k < 3 - l; k++) begin : g_lane
        logic [IW-1:0]   b_sel;
        logic [IW+T:0]   y_w;
        bzr_pkg::lerp_en_t len;

        assign len.diff = en[1 + 3*l];
        assign len.mul  = en[2 + 3*l];
        assign len.sum  = en[3 + 3*l];
        assign b_sel = (fsel[l] <= 2'(l)) ? lvl[a][l][k+1][IW-1:0] : lvl[a][l][k][IW-1:0];

        bzr_lerp #(.IW(IW)) u_lerp (
          .clk (clk),
          .en  (len),
          .a   (lvl[a][l][k][IW-1:0]),
          .b   (b_sel),
          .t   (tsel[l]),
          .y   (y_w)
        );

        assign lvl[a][l+1][k] = W3'($signed(y_w));
      end
    end

    bzr_round #(.VW(W3), .SHIFT(3 * T)) u_round (
      .v (lvl[a][3][0]),
      .q (res[a])
    );
  end

  always_ff @(posedge clk) begin
    if (en[NST-1]) begin
      rsp_q.out_x <= res[0];
      rsp_q.out_y <= res[1];
    end
  end

  assign rsp       = rsp_q;
  assign rsp_valid = v[NST-1];
  assign req_ready = en[0];

  a_ready_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> (&v) && !rsp_ready)
    else $error("req_ready low although the pipeline has room");

  a_accept_fills_stage0: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> v[0])
    else $error("accepted transaction did not reach the hull stage");

  a_stall_chain: assert property (@(posedge clk) disable iff (rst)
    !en[4] |-> v[4] && v[5] && !en[5])
    else $error("stall chain inconsistent in the middle of the pipeline");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !(|v) |-> req_ready)
    else $error("empty pipeline refuses a transaction");

endmodule

>>> tb/sv/cubic_bezier_point_and_derivatives_top_test.sv
module cubic_bezier_point_and_derivatives_top_test;
  import bzr_pkg::*;

  localparam int CLK_HALF    = 4;
  localparam int LONG_STALL  = 300;
  localparam int TIMEOUT_CYC = 200000;
  localparam int ITEMS_PER_CURVE = 61;
  localparam logic [T_FRAC_BITS:0] T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};

  typedef enum int {
    CURVE_RANDOM,
    CURVE_MAX,
    CURVE_MIN,
    CURVE_ZIGZAG,
    CURVE_SMALL
  } curve_kind_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 req_valid = 1'b0;
  logic                 req_ready;
  req_t                 req       = '0;
  logic                 rsp_valid;
  logic                 rsp_ready = 1'b0;
  rsp_t                 rsp;
  logic                 psel      = 1'b0;
  logic                 penable   = 1'b0;
  logic                 pwrite    = 1'b0;
  logic [ADDR_BITS-1:0] paddr     = '0;
  logic [DATA_BITS-1:0] pwdata    = '0;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;

  // Copy of the control points as the block holds them.
  logic signed [15:0] ctrl_pt [NUM_REGS];

  req_t pending_req_q [$];
  rsp_t expected_pt_q [$];

  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  int stall_requests = 0;
  int stall_seen     = 0;
  int stall_left     = 0;
  int fail_count     = 0;
  int items_accepted = 0;
  int points_checked = 0;
  int curves_loaded  = 0;

  cubic_bezier_point_and_derivatives_top dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #CLK_HALF clk = ~clk;

  // Bernstein sum over the difference hull of one axis, rounded half up and
  // clamped to the output width.
  function automatic logic signed [OUT_BITS-1:0] bezier_axis(
    func_t f, logic [T_FRAC_BITS:0] tq, int axis);
    logic signed [127:0] hull [4];
    logic signed [127:0] tw, uw, acc, term;
    int deg, shift, coef;
    for (int k = 0; k < 4; k++) hull[k] = 128'(ctrl_pt[2*k + axis]);
    deg = 3;
    if (f != FUNC_POS) begin
      for (int k = 0; k < 3; k++) hull[k] = 3 * (hull[k+1] - hull[k]);
      deg = 2;
    end
    if (f == FUNC_D2 || f == FUNC_D3) begin
      for (int k = 0; k < 2; k++) hull[k] = 2 * (hull[k+1] - hull[k]);
      deg = 1;
    end
    if (f == FUNC_D3) begin
      hull[0] = hull[1] - hull[0];
      deg = 0;
    end
    tw  = $signed({111'd0, tq});
    uw  = (128'sd1 <<< T_FRAC_BITS) - tw;
    acc = '0;
    for (int k = 0; k <= deg; k++) begin
      coef = ((deg == 3 && (k == 1 || k == 2)) ? 3 : ((deg == 2 && k == 1) ? 2 : 1));
      term = hull[k] * coef;
      for (int j = 0; j < deg - k; j++) term = term * uw;
      for (int j = 0; j < k; j++) term = term * tw;
      acc = acc + term;
    end
    shift = deg * T_FRAC_BITS;
    if (shift > 0) acc = (acc + (128'sd1 <<< (shift - 1))) >>> shift;
    if (acc > OUT_MAX) return OUT_BITS'(OUT_MAX);
    if (acc < OUT_MIN) return OUT_BITS'(OUT_MIN);
    return acc[OUT_BITS-1:0];
  endfunction

  function automatic rsp_t bezier_point(req_t r);
    rsp_t res;
    logic [T_FRAC_BITS:0] tq;
    tq = (r.t > T_ONE) ? T_ONE : r.t;
    res.out_x = bezier_axis(r.func, tq, 0);
    res.out_y = bezier_axis(r.func, tq, 1);
    return res;
  endfunction

  function automatic req_t random_request();
    req_t r;
    r.func = func_t'(2'($urandom_range(3)));
    case ($urandom_range(9))
      0: r.t = '0;
      1: r.t = T_ONE;
      2: r.t = (T_FRAC_BITS+1)'($urandom_range(2*T_ONE - 1, T_ONE + 1));
      3: r.t = (T_FRAC_BITS+1)'($urandom_range(15));
      default: r.t = (T_FRAC_BITS+1)'($urandom_range(T_ONE));
    endcase
    return r;
  endfunction

  // Request driver: the payload is held until the transaction is taken.
  always @(posedge clk) begin : req_driver
    logic nxt_valid;
    req_t nxt_req;
    if (rst) begin
      req_valid <= 1'b0;
      req       <= '0;
    end else begin
      nxt_valid = req_valid;
      nxt_req   = req;
      if (req_valid && req_ready) begin
        expected_pt_q.push_back(bezier_point(req));
        items_accepted++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && pending_req_q.size() != 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        nxt_req   = pending_req_q.pop_front();
        nxt_valid = 1'b1;
      end
      req_valid <= nxt_valid;
      req       <= nxt_req;
    end
  end

  always @(posedge clk) begin : rsp_receiver
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (stall_requests != stall_seen) begin
        stall_seen = stall_requests;
        stall_left = LONG_STALL;
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : rsp_checker
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      points_checked++;
      if (expected_pt_q.size() == 0) begin
        $error("result with nothing outstanding: out_x %0d out_y %0d", rsp.out_x, rsp.out_y);
        fail_count++;
      end else begin
        want = expected_pt_q.pop_front();
        if (rsp.out_x !== want.out_x) begin
          $error("out_x mismatch: expected %0d, got %0d", want.out_x, rsp.out_x);
          fail_count++;
        end
        if (rsp.out_y !== want.out_y) begin
          $error("out_y mismatch: expected %0d, got %0d", want.out_y, rsp.out_y);
          fail_count++;
        end
      end
    end
  end

  task automatic reg_write(int idx, logic signed [15:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_BITS'(idx * 4);
    pwdata  <= DATA_BITS'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    ctrl_pt[idx] = val;
  endtask

  task automatic set_point(int x_reg, logic signed [15:0] px, logic signed [15:0] py);
    reg_write(x_reg, px);
    reg_write(x_reg + 1, py);
  endtask

  task automatic load_curve(curve_kind_t kind);
    logic signed [15:0] px, py;
    for (int k = 0; k < 4; k++) begin
      case (kind)
        CURVE_MAX: begin
          px = 16'sh7fff;
          py = 16'sh7fff;
        end
        CURVE_MIN: begin
          px = 16'sh8000;
          py = 16'sh8000;
        end
        CURVE_ZIGZAG: begin
          px = k[0] ? 16'sh7fff : 16'sh8000;
          py = k[0] ? 16'sh8000 : 16'sh7fff;
        end
        CURVE_SMALL: begin
          px = $signed(16'($urandom_range(31))) - 16'sd16;
          py = $signed(16'($urandom_range(31))) - 16'sd16;
        end
        default: begin
          px = 16'($urandom);
          py = 16'($urandom);
        end
      endcase
      set_point(REG_P0_X + 2*k, px, py);
    end
    curves_loaded++;
  endtask

  task automatic wait_drained();
    while (pending_req_q.size() != 0 || req_valid || expected_pt_q.size() != 0)
      @(posedge clk);
  endtask

  initial begin : stimulus
    logic [T_FRAC_BITS:0] corner_t [5];
    req_t r;
    corner_t = '{'0, (T_FRAC_BITS+1)'(1), T_ONE >> 1, T_ONE,
                 (T_FRAC_BITS+1)'(2*T_ONE - 1)};
    for (int i = 0; i < NUM_REGS; i++) ctrl_pt[i] = '0;
    send_idle_pct <= 27;
    recv_idle_pct <= 56;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Largest swings between neighbouring points: derivatives at their extremes.
    load_curve(CURVE_ZIGZAG);
    for (int f = 0; f < 4; f++) begin
      foreach (corner_t[i]) begin
        r.func = func_t'(f);
        r.t    = corner_t[i];
        pending_req_q.push_back(r);
      end
    end
    wait_drained();

    // Half-way cases at t = 1/2: +0.5 rounds up to 1, -0.5 rounds up to 0.
    set_point(REG_P0_X, 16'sd4, -16'sd4);
    set_point(REG_P1_X, 16'sd0, 16'sd0);
    set_point(REG_P2_X, 16'sd0, 16'sd0);
    set_point(REG_P3_X, 16'sd0, 16'sd0);
    curves_loaded++;
    r.func = FUNC_POS;
    r.t    = T_ONE >> 1;
    pending_req_q.push_back(r);
    r.t    = T_ONE + 1'b1;
    pending_req_q.push_back(r);
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct <= 27;
          recv_idle_pct <= 56;
        end
        1: begin
          send_idle_pct <= 56;
          recv_idle_pct <= 27;
        end
        default: begin
          send_idle_pct <= 0;
          recv_idle_pct <= 0;
        end
      endcase
      for (int c = 0; c < 3; c++) begin
        wait_drained();
        load_curve(curve_kind_t'((phase * 3 + c) % 5));
        // Hold the output back while a full batch is offered, so the pipeline backs up.
        if (phase == 2 && c == 2) stall_requests <= stall_requests + 1;
        repeat (ITEMS_PER_CURVE) pending_req_q.push_back(random_request());
      end
    end
    wait_drained();
    repeat (20) @(posedge clk);

    $display("Ran %0d transactions over %0d control point sets; %0d points checked.",
             items_accepted, curves_loaded, points_checked);
    $display("Covered all derivative orders, t at 0, 1 and above 1, ties and a long output stall.");
    if (fail_count == 0 && expected_pt_q.size() == 0) begin
      $display("cubic_bezier_point_and_derivatives_top_test: PASS");
    end else begin
      $display("cubic_bezier_point_and_derivatives_top_test: FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #(2 * CLK_HALF * TIMEOUT_CYC);
    $display("Timed out with %0d results outstanding.", expected_pt_q.size());
    $display("cubic_bezier_point_and_derivatives_top_test: FAIL");
    $finish;
  end

endmodule

>>> filelist.f
rtl/bzr_pkg.sv
rtl/bzr_cfg.sv
rtl/bzr_hull.sv
rtl/bzr_lerp.sv
rtl/bzr_round.sv
rtl/cubic_bezier_point_and_derivatives_top.sv
tb/sv/cubic_bezier_point_and_derivatives_top_test.sv
